// ===== rtl/xss_pkg.sv =====
`default_nettype none
package xss_pkg;

   localparam int SECTOR_BYTES = 128;
   localparam int FRAME_LEN    = SECTOR_BYTES + 4;
   localparam int ADDR_W       = $clog2(SECTOR_BYTES);
   localparam int FILL_W       = $clog2(SECTOR_BYTES + 1);
   localparam int FIDX_W       = $clog2(FRAME_LEN + 1);

   // line characters
   localparam logic [7:0] CH_SOH = 8'h01;
   localparam logic [7:0] CH_EOT = 8'h04;
   localparam logic [7:0] CH_ACK = 8'h06;
   localparam logic [7:0] CH_NAK = 8'h15;

   // request operations
   localparam logic [2:0] OP_START   = 3'd0;
   localparam logic [2:0] OP_LOAD    = 3'd1;
   localparam logic [2:0] OP_EOF     = 3'd2;
   localparam logic [2:0] OP_TXSLOT  = 3'd3;
   localparam logic [2:0] OP_RXBYTE  = 3'd4;
   localparam logic [2:0] OP_TIMEOUT = 3'd5;
   localparam logic [2:0] OP_ABORT   = 3'd6;

   // transfer phases
   localparam logic [2:0] PH_IDLE    = 3'd0;
   localparam logic [2:0] PH_SYNC    = 3'd1;
   localparam logic [2:0] PH_LOAD    = 3'd2;
   localparam logic [2:0] PH_SEND    = 3'd3;
   localparam logic [2:0] PH_WAIT    = 3'd4;
   localparam logic [2:0] PH_EOT     = 3'd5;
   localparam logic [2:0] PH_EOTWAIT = 3'd6;
   localparam logic [2:0] PH_DONE    = 3'd7;

   // outcomes
   localparam logic [2:0] OC_RUNNING    = 3'd0;
   localparam logic [2:0] OC_EOT_ACKED  = 3'd1;
   localparam logic [2:0] OC_EOT_NOACK  = 3'd2;
   localparam logic [2:0] OC_EOT_TMO    = 3'd3;
   localparam logic [2:0] OC_NO_SYNC    = 3'd4;
   localparam logic [2:0] OC_SECT_NOACK = 3'd5;
   localparam logic [2:0] OC_ABORTED    = 3'd6;

   // configuration register indexes
   localparam logic [1:0] REG_RETRY_LIMIT = 2'd0;
   localparam logic [1:0] REG_SYNC_LIMIT  = 2'd1;
   localparam logic [1:0] REG_PAD_BYTE    = 2'd2;

   // kind of byte a transmit slot produces
   typedef enum logic [2:0] {
      KIND_NONE,
      KIND_SOH,
      KIND_NUM,
      KIND_CPL,
      KIND_DATA,
      KIND_SUM,
      KIND_EOT
   } kind_type;

   typedef struct packed {
      kind_type   kind;
      logic       use_pad;
      logic [2:0] phase;
      logic [2:0] outcome;
      logic [7:0] sector;
      logic [3:0] attempt;
   } slot_type;

   function automatic logic [3:0] bump4(input logic [3:0] v);
      bump4 = (v == 4'hf) ? 4'hf : v + 4'd1;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/xmodem_sector_sender.sv =====
// XMODEM checksum sender, one request in, one response out.
// Requests (req_*) carry an operation in req_tuser: start, load file byte,
// end of file, transmit slot, received byte, timeout or abort. Every
// accepted request yields exactly one response (rsp_*) that carries the
// frame byte to send (valid only for a transmit slot in a send phase) and
// the transfer status after the request: phase, outcome, sector and attempt.
// Configuration (csr_*) writes retry limit, sync limit and pad byte; write
// it only while no request is in flight.
// File bytes land in a 128-entry sector store; transmit slots read it back
// in frame order, padding past the fill count with the pad byte.
// A request passes the middle stage (control update and store read) and
// then the output register before its response appears. Throughput: one
// request per cycle while the receiver keeps up, bounded by the single
// store access each request makes.
// Reset restores the register defaults and goes idle; the sector store is
// not cleared, since only written entries ever reach the output.
// When the receiver stalls, the output register holds its response, the
// middle stage fills, and then req_tready drops until rsp_tready returns.
`default_nettype none
module xmodem_sector_sender (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_addr,
   input  wire logic [7:0]  csr_wdata,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,   // file_byte[7:0], rx_byte[15:8]
   input  wire logic [2:0]  req_tuser,   // operation[2:0]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata,   // tx_byte[7:0], want_data[8], phase[11:9],
                                         // finished[12], outcome[15:13],
                                         // sector_number[23:16], attempt_number[27:24]
   output logic [0:0]       rsp_tuser    // tx_valid[0]
);

   localparam int ADDR_W = xss_pkg::ADDR_W;
   localparam int FILL_W = xss_pkg::FILL_W;
   localparam int FIDX_W = xss_pkg::FIDX_W;

   // configuration
   logic [3:0] retry_limit_ff, sync_limit_ff;
   logic [7:0] pad_byte_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         retry_limit_ff <= 4'd10;
         sync_limit_ff  <= 4'd10;
         pad_byte_ff    <= 8'h00;
      end else if (csr_we) begin
         unique case (csr_addr)
            xss_pkg::REG_RETRY_LIMIT: retry_limit_ff <= csr_wdata[3:0];
            xss_pkg::REG_SYNC_LIMIT:  sync_limit_ff  <= csr_wdata[3:0];
            xss_pkg::REG_PAD_BYTE:    pad_byte_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   // control state
   logic [2:0]        phase_ff, phase_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic              eof_ff, eof_in;
   logic [7:0]        sector_ff, sector_in;
   logic [3:0]        attempt_ff, attempt_in;
   logic [3:0]        sync_ff, sync_in;
   logic [FIDX_W-1:0] fidx_ff, fidx_in;
   logic [2:0]        outcome_ff, outcome_in;

   // pipeline
   logic                 s1_valid_ff;
   xss_pkg::slot_type    s1_ff, s1_in;
   logic                 out_valid_ff;
   logic                 out_txv_ff;
   logic [7:0]           out_txb_ff;
   logic [2:0]           out_phase_ff, out_outcome_ff;
   logic [7:0]           out_sector_ff;
   logic [3:0]           out_attempt_ff;
   logic [7:0]           sum_ff, sum_in;

   logic s1_advance, accept;
   logic [2:0] op;
   logic [7:0] file_byte, rx_byte;

   // sector store
   logic [7:0]        store [xss_pkg::SECTOR_BYTES];
   logic [7:0]        rd_data_ff;
   logic              wr_en, rd_en;
   logic [ADDR_W-1:0] rd_addr;
   logic [FIDX_W-1:0] data_idx;

   assign op        = req_tuser;
   assign file_byte = req_tdata[7:0];
   assign rx_byte   = req_tdata[15:8];

   assign s1_advance = !out_valid_ff || rsp_tready;
   assign req_tready = !s1_valid_ff || s1_advance;
   assign accept     = req_tvalid && req_tready;

   assign data_idx = fidx_ff - FIDX_W'(3);
   assign rd_addr  = data_idx[ADDR_W-1:0];

   // control update: one request per cycle while req_tready is high
   always_comb begin
      phase_in   = phase_ff;
      fill_in    = fill_ff;
      eof_in     = eof_ff;
      sector_in  = sector_ff;
      attempt_in = attempt_ff;
      sync_in    = sync_ff;
      fidx_in    = fidx_ff;
      outcome_in = outcome_ff;
      wr_en      = 1'b0;
      rd_en      = 1'b0;
      s1_in.kind    = xss_pkg::KIND_NONE;
      s1_in.use_pad = 1'b0;

      case (op)
         xss_pkg::OP_START: begin
            if (phase_ff == xss_pkg::PH_IDLE || phase_ff == xss_pkg::PH_DONE) begin
               phase_in   = xss_pkg::PH_SYNC;
               fill_in    = '0;
               eof_in     = 1'b0;
               sector_in  = 8'd1;
               attempt_in = 4'd0;
               sync_in    = 4'd0;
               fidx_in    = '0;
               outcome_in = xss_pkg::OC_RUNNING;
            end
         end
         xss_pkg::OP_LOAD: begin
            if (phase_ff == xss_pkg::PH_LOAD) begin
               wr_en   = 1'b1;
               fill_in = fill_ff + FILL_W'(1);
               if (fill_in >= FILL_W'(xss_pkg::SECTOR_BYTES)) begin
                  attempt_in = 4'd0;
                  phase_in   = xss_pkg::PH_SEND;
                  fidx_in    = '0;
               end
            end
         end
         xss_pkg::OP_EOF: begin
            if (phase_ff == xss_pkg::PH_LOAD) begin
               eof_in     = 1'b1;
               attempt_in = 4'd0;
               if (fill_ff == '0) begin
                  phase_in = xss_pkg::PH_EOT;
               end else begin
                  phase_in = xss_pkg::PH_SEND;
                  fidx_in  = '0;
               end
            end
         end
         xss_pkg::OP_TXSLOT: begin
            if (phase_ff == xss_pkg::PH_SEND) begin
               if (fidx_ff == '0) begin
                  s1_in.kind = xss_pkg::KIND_SOH;
               end else if (fidx_ff == FIDX_W'(1)) begin
                  s1_in.kind = xss_pkg::KIND_NUM;
               end else if (fidx_ff == FIDX_W'(2)) begin
                  s1_in.kind = xss_pkg::KIND_CPL;
               end else if (fidx_ff < FIDX_W'(xss_pkg::SECTOR_BYTES + 3)) begin
                  s1_in.kind    = xss_pkg::KIND_DATA;
                  s1_in.use_pad = (FILL_W'(data_idx) >= fill_ff);
                  rd_en         = 1'b1;
               end else begin
                  s1_in.kind = xss_pkg::KIND_SUM;
               end
               fidx_in = fidx_ff + FIDX_W'(1);
               if (fidx_in >= FIDX_W'(xss_pkg::FRAME_LEN)) begin
                  attempt_in = xss_pkg::bump4(attempt_ff);
                  phase_in   = xss_pkg::PH_WAIT;
               end
            end else if (phase_ff == xss_pkg::PH_EOT) begin
               s1_in.kind = xss_pkg::KIND_EOT;
               attempt_in = xss_pkg::bump4(attempt_ff);
               phase_in   = xss_pkg::PH_EOTWAIT;
            end
         end
         xss_pkg::OP_RXBYTE, xss_pkg::OP_TIMEOUT: begin
            if (phase_ff == xss_pkg::PH_SYNC) begin
               if (op == xss_pkg::OP_RXBYTE && rx_byte == xss_pkg::CH_NAK) begin
                  phase_in = xss_pkg::PH_LOAD;
                  fill_in  = '0;
               end else begin
                  sync_in = xss_pkg::bump4(sync_ff);
                  if (sync_in >= sync_limit_ff) begin
                     phase_in   = xss_pkg::PH_DONE;
                     outcome_in = xss_pkg::OC_NO_SYNC;
                  end
               end
            end else if (phase_ff == xss_pkg::PH_WAIT) begin
               if (op == xss_pkg::OP_RXBYTE && rx_byte == xss_pkg::CH_ACK) begin
                  sector_in  = sector_ff + 8'd1;
                  attempt_in = 4'd0;
                  if (eof_ff) begin
                     phase_in = xss_pkg::PH_EOT;
                  end else begin
                     phase_in = xss_pkg::PH_LOAD;
                     fill_in  = '0;
                  end
               end else if (attempt_ff >= retry_limit_ff) begin
                  phase_in   = xss_pkg::PH_DONE;
                  outcome_in = xss_pkg::OC_SECT_NOACK;
               end else begin
                  phase_in = xss_pkg::PH_SEND;
                  fidx_in  = '0;
               end
            end else if (phase_ff == xss_pkg::PH_EOTWAIT) begin
               phase_in = xss_pkg::PH_DONE;
               if (op == xss_pkg::OP_TIMEOUT) begin
                  outcome_in = xss_pkg::OC_EOT_TMO;
               end else if (rx_byte == xss_pkg::CH_ACK) begin
                  outcome_in = xss_pkg::OC_EOT_ACKED;
               end else if (attempt_ff >= retry_limit_ff) begin
                  outcome_in = xss_pkg::OC_EOT_NOACK;
               end else begin
                  phase_in = xss_pkg::PH_EOT;
               end
            end
         end
         xss_pkg::OP_ABORT: begin
            if (phase_ff != xss_pkg::PH_IDLE && phase_ff != xss_pkg::PH_DONE) begin
               phase_in   = xss_pkg::PH_DONE;
               outcome_in = xss_pkg::OC_ABORTED;
            end
         end
         default: ;
      endcase

      s1_in.phase   = phase_in;
      s1_in.outcome = outcome_in;
      s1_in.sector  = sector_in;
      s1_in.attempt = attempt_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= xss_pkg::PH_IDLE;
         fill_ff    <= '0;
         eof_ff     <= 1'b0;
         sector_ff  <= 8'd1;
         attempt_ff <= 4'd0;
         sync_ff    <= 4'd0;
         fidx_ff    <= '0;
         outcome_ff <= xss_pkg::OC_RUNNING;
      end else if (accept) begin
         phase_ff   <= phase_in;
         fill_ff    <= fill_in;
         eof_ff     <= eof_in;
         sector_ff  <= sector_in;
         attempt_ff <= attempt_in;
         sync_ff    <= sync_in;
         fidx_ff    <= fidx_in;
         outcome_ff <= outcome_in;
      end
   end

   // store: write a loaded byte, read the next data byte of the frame
   always_ff @(posedge clock) begin
      if (accept && wr_en) begin
         store[fill_ff[ADDR_W-1:0]] <= file_byte;
      end
      if (accept && rd_en) begin
         rd_data_ff <= store[rd_addr];
      end
   end

   // middle stage: hold the slot description next to the store read data
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (accept) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_advance) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff <= s1_in;
      end
   end

   // form the frame byte and keep the running checksum
   logic [7:0] data_byte, tx_byte;

   assign data_byte = s1_ff.use_pad ? pad_byte_ff : rd_data_ff;

   always_comb begin
      sum_in = sum_ff;
      case (s1_ff.kind)
         xss_pkg::KIND_SOH:  tx_byte = xss_pkg::CH_SOH;
         xss_pkg::KIND_NUM:  tx_byte = s1_ff.sector;
         xss_pkg::KIND_CPL:  tx_byte = ~s1_ff.sector;
         xss_pkg::KIND_DATA: tx_byte = data_byte;
         xss_pkg::KIND_SUM:  tx_byte = sum_ff;
         xss_pkg::KIND_EOT:  tx_byte = xss_pkg::CH_EOT;
         default:            tx_byte = 8'h00;
      endcase
      // every frame opens with SOH, so restart the sum there
      if (s1_ff.kind == xss_pkg::KIND_SOH) begin
         sum_in = 8'h00;
      end else if (s1_ff.kind == xss_pkg::KIND_DATA) begin
         sum_in = sum_ff + data_byte;
      end
   end

   logic s1_move;
   assign s1_move = s1_valid_ff && s1_advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         sum_ff       <= 8'h00;
      end else begin
         if (s1_move) begin
            out_valid_ff <= 1'b1;
            sum_ff       <= sum_in;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move) begin
         out_txv_ff     <= (s1_ff.kind != xss_pkg::KIND_NONE);
         out_txb_ff     <= tx_byte;
         out_phase_ff   <= s1_ff.phase;
         out_outcome_ff <= s1_ff.outcome;
         out_sector_ff  <= s1_ff.sector;
         out_attempt_ff <= s1_ff.attempt;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_txv_ff;
   assign rsp_tdata  = {4'h0,
                        out_attempt_ff,
                        out_sector_ff,
                        out_outcome_ff,
                        (out_phase_ff == xss_pkg::PH_DONE),
                        out_phase_ff,
                        (out_phase_ff == xss_pkg::PH_LOAD),
                        out_txb_ff};

endmodule
`default_nettype wire

// ===== bench/tb_xmodem_sector_sender.sv =====
module tb_xmodem_sector_sender;

   // operation code that the block must ignore
   localparam logic [2:0] OP_UNUSED   = 3'd7;
   localparam int         CYCLE_LIMIT = 400000;
   localparam int         BUF_AW      = xss_pkg::ADDR_W;

   // one response, unpacked from rsp_tdata / rsp_tuser
   typedef struct packed {
      logic       tx_valid;
      logic [7:0] tx_byte;
      logic       want_data;
      logic [2:0] phase;
      logic       finished;
      logic [2:0] outcome;
      logic [7:0] sector;
      logic [3:0] attempt;
   } reply_type;

   // block ports; every input starts at a known value
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_we = 1'b0;
   logic [1:0]  csr_addr = '0;
   logic [7:0]  csr_wdata = '0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;   // file_byte[7:0], rx_byte[15:8]
   logic [2:0]  req_tuser = '0;   // operation[2:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;        // tx_byte[7:0], want_data[8], phase[11:9], finished[12],
                                  // outcome[15:13], sector_number[23:16],
                                  // attempt_number[27:24]
   logic [0:0]  rsp_tuser;        // tx_valid[0]

   xmodem_sector_sender dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #5 clock = ~clock;

   // ------------------------------------------------------------------
   // Transfer predictor: a private copy of the sender's state and
   // registers, advanced once per accepted request.
   // ------------------------------------------------------------------
   logic [3:0] retry_max = 4'd10;
   logic [3:0] sync_max  = 4'd10;
   logic [7:0] pad_value = 8'h00;

   logic [2:0] xfer_phase   = xss_pkg::PH_IDLE;
   logic [7:0] sector_buf [xss_pkg::SECTOR_BYTES];
   int         fill_level   = 0;
   logic       eof_flag     = 1'b0;
   logic [7:0] sector_no    = 8'd1;
   logic [3:0] attempts     = 4'd0;
   logic [3:0] sync_tries   = 4'd0;
   int         frame_pos    = 0;
   logic [7:0] frame_sum    = 8'd0;
   logic [2:0] xfer_outcome = xss_pkg::OC_RUNNING;

   reply_type replies_due [$];   // predicted responses, oldest first

   int send_idle_pct  = 25;
   int rsp_idle_pct   = 69;
   int request_count  = 0;
   int response_count = 0;
   int error_count    = 0;
   int cycle_count    = 0;

   function automatic logic [3:0] sat_inc(input logic [3:0] v);
      return (v == 4'hf) ? v : v + 4'd1;
   endfunction

   // rewind to the first byte of the frame and go transmit it
   function automatic void open_frame();
      xfer_phase = xss_pkg::PH_SEND;
      frame_pos  = 0;
      frame_sum  = 8'd0;
   endfunction

   function automatic reply_type next_reply(input logic [2:0] op, input logic [7:0] fb,
                                            input logic [7:0] rb);
      reply_type r;
      int        pos;
      r = '0;
      case (op) inside
         xss_pkg::OP_START: begin
            // a start while running is dropped; from idle or done it restarts
            if (xfer_phase == xss_pkg::PH_IDLE || xfer_phase == xss_pkg::PH_DONE) begin
               xfer_phase   = xss_pkg::PH_SYNC;
               fill_level   = 0;
               eof_flag     = 1'b0;
               sector_no    = 8'd1;
               attempts     = 4'd0;
               sync_tries   = 4'd0;
               frame_pos    = 0;
               frame_sum    = 8'd0;
               xfer_outcome = xss_pkg::OC_RUNNING;
            end
         end
         xss_pkg::OP_LOAD: begin
            if (xfer_phase == xss_pkg::PH_LOAD) begin
               sector_buf[BUF_AW'(fill_level)] = fb;
               fill_level++;
               if (fill_level >= xss_pkg::SECTOR_BYTES) begin
                  attempts = 4'd0;
                  open_frame();
               end
            end
         end
         xss_pkg::OP_EOF: begin
            if (xfer_phase == xss_pkg::PH_LOAD) begin
               eof_flag = 1'b1;
               attempts = 4'd0;
               // nothing buffered: skip the frame and go straight to the end mark
               if (fill_level == 0) begin
                  xfer_phase = xss_pkg::PH_EOT;
               end else begin
                  open_frame();
               end
            end
         end
         xss_pkg::OP_TXSLOT: begin
            if (xfer_phase == xss_pkg::PH_SEND) begin
               pos = frame_pos;
               r.tx_valid = 1'b1;
               if (pos == 0) begin
                  r.tx_byte = xss_pkg::CH_SOH;
               end else if (pos == 1) begin
                  r.tx_byte = sector_no;
               end else if (pos == 2) begin
                  r.tx_byte = ~sector_no;
               end else if (pos < xss_pkg::SECTOR_BYTES + 3) begin
                  // past the fill level a short sector is padded
                  r.tx_byte = (pos - 3 < fill_level) ? sector_buf[BUF_AW'(pos - 3)]
                                                     : pad_value;
                  frame_sum = frame_sum + r.tx_byte;
               end else begin
                  r.tx_byte = frame_sum;
               end
               frame_pos = pos + 1;
               if (frame_pos >= xss_pkg::FRAME_LEN) begin
                  attempts   = sat_inc(attempts);
                  xfer_phase = xss_pkg::PH_WAIT;
               end
            end else if (xfer_phase == xss_pkg::PH_EOT) begin
               r.tx_valid = 1'b1;
               r.tx_byte  = xss_pkg::CH_EOT;
               attempts   = sat_inc(attempts);
               xfer_phase = xss_pkg::PH_EOTWAIT;
            end
         end
         xss_pkg::OP_RXBYTE, xss_pkg::OP_TIMEOUT: begin
            if (xfer_phase == xss_pkg::PH_SYNC) begin
               // a NAK is taken even on the last allowed try
               if (op == xss_pkg::OP_RXBYTE && rb == xss_pkg::CH_NAK) begin
                  xfer_phase = xss_pkg::PH_LOAD;
                  fill_level = 0;
               end else begin
                  sync_tries = sat_inc(sync_tries);
                  if (sync_tries >= sync_max) begin
                     xfer_phase   = xss_pkg::PH_DONE;
                     xfer_outcome = xss_pkg::OC_NO_SYNC;
                  end
               end
            end else if (xfer_phase == xss_pkg::PH_WAIT) begin
               if (op == xss_pkg::OP_RXBYTE && rb == xss_pkg::CH_ACK) begin
                  sector_no = sector_no + 8'd1;
                  attempts  = 4'd0;
                  if (eof_flag) begin
                     xfer_phase = xss_pkg::PH_EOT;
                  end else begin
                     xfer_phase = xss_pkg::PH_LOAD;
                     fill_level = 0;
                  end
               end else if (attempts >= retry_max) begin
                  xfer_phase   = xss_pkg::PH_DONE;
                  xfer_outcome = xss_pkg::OC_SECT_NOACK;
               end else begin
                  open_frame();
               end
            end else if (xfer_phase == xss_pkg::PH_EOTWAIT) begin
               // a timeout here ends the run whatever the retry count
               if (op == xss_pkg::OP_TIMEOUT) begin
                  xfer_phase   = xss_pkg::PH_DONE;
                  xfer_outcome = xss_pkg::OC_EOT_TMO;
               end else if (rb == xss_pkg::CH_ACK) begin
                  xfer_phase   = xss_pkg::PH_DONE;
                  xfer_outcome = xss_pkg::OC_EOT_ACKED;
               end else if (attempts >= retry_max) begin
                  xfer_phase   = xss_pkg::PH_DONE;
                  xfer_outcome = xss_pkg::OC_EOT_NOACK;
               end else begin
                  xfer_phase = xss_pkg::PH_EOT;
               end
            end
         end
         xss_pkg::OP_ABORT: begin
            if (xfer_phase != xss_pkg::PH_IDLE && xfer_phase != xss_pkg::PH_DONE) begin
               xfer_phase   = xss_pkg::PH_DONE;
               xfer_outcome = xss_pkg::OC_ABORTED;
            end
         end
         default: begin
         end
      endcase
      r.want_data = (xfer_phase == xss_pkg::PH_LOAD);
      r.phase     = xfer_phase;
      r.finished  = (xfer_phase == xss_pkg::PH_DONE);
      r.outcome   = xfer_outcome;
      r.sector    = sector_no;
      r.attempt   = attempts;
      return r;
   endfunction

   // ------------------------------------------------------------------
   // Response side: random backpressure and the scoreboard check
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= rsp_idle_pct);
   end

   task automatic flag_mismatch(input string field, input int got, input int want_val);
      $display("ERROR response %0d: %s is %0d, predicted %0d",
               response_count, field, got, want_val);
      error_count++;
   endtask

   reply_type seen_reply;
   reply_type due_reply;

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen_reply.tx_valid  = rsp_tuser[0];
         seen_reply.tx_byte   = rsp_tdata[7:0];
         seen_reply.want_data = rsp_tdata[8];
         seen_reply.phase     = rsp_tdata[11:9];
         seen_reply.finished  = rsp_tdata[12];
         seen_reply.outcome   = rsp_tdata[15:13];
         seen_reply.sector    = rsp_tdata[23:16];
         seen_reply.attempt   = rsp_tdata[27:24];
         if (replies_due.size() == 0) begin
            flag_mismatch("response with no request outstanding", 1, 0);
         end else begin
            due_reply = replies_due.pop_front();
            if (seen_reply.tx_valid !== due_reply.tx_valid)
               flag_mismatch("tx_valid", seen_reply.tx_valid, due_reply.tx_valid);
            if (seen_reply.tx_byte !== due_reply.tx_byte)
               flag_mismatch("tx_byte", seen_reply.tx_byte, due_reply.tx_byte);
            if (seen_reply.want_data !== due_reply.want_data)
               flag_mismatch("want_data", seen_reply.want_data, due_reply.want_data);
            if (seen_reply.phase !== due_reply.phase)
               flag_mismatch("phase", seen_reply.phase, due_reply.phase);
            if (seen_reply.finished !== due_reply.finished)
               flag_mismatch("finished", seen_reply.finished, due_reply.finished);
            if (seen_reply.outcome !== due_reply.outcome)
               flag_mismatch("outcome", seen_reply.outcome, due_reply.outcome);
            if (seen_reply.sector !== due_reply.sector)
               flag_mismatch("sector_number", seen_reply.sector, due_reply.sector);
            if (seen_reply.attempt !== due_reply.attempt)
               flag_mismatch("attempt_number", seen_reply.attempt, due_reply.attempt);
         end
         response_count++;
      end
   end

   // hard stop if the block hangs
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Request side
   // ------------------------------------------------------------------

   // Offer one request, with random gaps ahead of it; return at the edge that
   // takes it. Valid stays high so the next request can follow back to back.
   task automatic send_request(input logic [2:0] op, input logic [7:0] fb,
                               input logic [7:0] rb);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {rb, fb};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      replies_due.push_back(next_reply(op, fb, rb));
      request_count++;
   endtask

   // unused fields carry random bytes
   task automatic put_op(input logic [2:0] op);
      send_request(op, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
   endtask

   task automatic put_rx(input logic [7:0] b);
      send_request(xss_pkg::OP_RXBYTE, 8'($urandom_range(0, 255)), b);
   endtask

   task automatic put_file(input logic [7:0] b);
      send_request(xss_pkg::OP_LOAD, b, 8'($urandom_range(0, 255)));
   endtask

   task automatic send_slots(input int n);
      repeat (n) put_op(xss_pkg::OP_TXSLOT);
   endtask

   // drop valid, wait out every outstanding response plus the pipeline
   task automatic settle();
      req_tvalid <= 1'b0;
      while (replies_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // write one register; call only after settle()
   task automatic write_reg(input logic [1:0] addr, input logic [7:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      case (addr)
         xss_pkg::REG_RETRY_LIMIT: retry_max = value[3:0];
         xss_pkg::REG_SYNC_LIMIT:  sync_max  = value[3:0];
         xss_pkg::REG_PAD_BYTE:    pad_value = value;
         default: begin
         end
      endcase
   endtask

   function automatic logic [7:0] pick_limit();
      case ($urandom_range(0, 3))
         0:       return 8'd1;
         1:       return 8'd15;
         default: return 8'($urandom_range(1, 15));
      endcase
   endfunction

   // ------------------------------------------------------------------
   // Directed tests
   // ------------------------------------------------------------------

   // requests that do not fit the phase, the unused code, start while
   // running, and abort in idle and done
   task automatic test_ignored_requests();
      put_op(xss_pkg::OP_LOAD);
      put_op(xss_pkg::OP_EOF);
      put_op(xss_pkg::OP_TXSLOT);
      put_rx(xss_pkg::CH_NAK);
      put_op(xss_pkg::OP_TIMEOUT);
      put_op(xss_pkg::OP_ABORT);
      put_op(OP_UNUSED);
      put_op(xss_pkg::OP_START);
      put_op(xss_pkg::OP_START);
      put_file(8'hff);
      put_op(xss_pkg::OP_EOF);
      put_op(xss_pkg::OP_TXSLOT);
      put_op(OP_UNUSED);
      put_op(xss_pkg::OP_ABORT);
      put_op(xss_pkg::OP_ABORT);
      put_rx(xss_pkg::CH_NAK);
   endtask

   // sync limit zero, NAK on the last try, limit 15 used up, limit one
   task automatic test_sync_limits();
      settle();
      write_reg(xss_pkg::REG_SYNC_LIMIT, 8'd0);
      put_op(xss_pkg::OP_START);
      put_op(xss_pkg::OP_TIMEOUT);
      settle();
      write_reg(xss_pkg::REG_SYNC_LIMIT, 8'd3);
      put_op(xss_pkg::OP_START);
      put_rx(8'h00);
      put_op(xss_pkg::OP_TIMEOUT);
      put_rx(xss_pkg::CH_NAK);
      put_rx(xss_pkg::CH_ACK);
      put_op(xss_pkg::OP_TIMEOUT);
      put_op(xss_pkg::OP_ABORT);
      settle();
      write_reg(xss_pkg::REG_SYNC_LIMIT, 8'd15);
      put_op(xss_pkg::OP_START);
      repeat (15) put_rx(8'hff);
      settle();
      write_reg(xss_pkg::REG_SYNC_LIMIT, 8'd1);
      put_op(xss_pkg::OP_START);
      put_rx(xss_pkg::CH_ACK);
   endtask

   // end of file with nothing buffered: end mark retries, retry limit zero,
   // timeout on the end mark, and a clean ACK
   task automatic test_empty_file();
      settle();
      write_reg(xss_pkg::REG_RETRY_LIMIT, 8'd0);
      put_op(xss_pkg::OP_START);
      put_rx(xss_pkg::CH_NAK);
      put_op(xss_pkg::OP_EOF);
      put_op(xss_pkg::OP_TXSLOT);
      put_rx(xss_pkg::CH_NAK);
      settle();
      write_reg(xss_pkg::REG_RETRY_LIMIT, 8'd2);
      put_op(xss_pkg::OP_START);
      put_rx(xss_pkg::CH_NAK);
      put_op(xss_pkg::OP_EOF);
      put_op(xss_pkg::OP_TXSLOT);
      put_rx(8'haa);
      put_op(xss_pkg::OP_TXSLOT);
      put_op(xss_pkg::OP_TIMEOUT);
      put_op(xss_pkg::OP_START);
      put_rx(xss_pkg::CH_NAK);
      put_op(xss_pkg::OP_EOF);
      put_op(xss_pkg::OP_TXSLOT);
      put_rx(xss_pkg::CH_ACK);
   endtask

   // short final sector padded with all-ones and all-zeros, one resend,
   // sector given up at retry limit one
   task automatic test_short_sector();
      settle();
      write_reg(xss_pkg::REG_RETRY_LIMIT, 8'd1);
      write_reg(xss_pkg::REG_PAD_BYTE, 8'hff);
      put_op(xss_pkg::OP_START);
      put_rx(xss_pkg::CH_NAK);
      put_file(8'h00);
      put_file(8'hff);
      put_file(8'h5a);
      put_op(xss_pkg::OP_EOF);
      put_rx(xss_pkg::CH_ACK);
      put_file(8'h33);
      send_slots(xss_pkg::FRAME_LEN);
      put_op(xss_pkg::OP_TIMEOUT);
      settle();
      write_reg(xss_pkg::REG_RETRY_LIMIT, 8'd15);
      write_reg(xss_pkg::REG_PAD_BYTE, 8'h00);
      put_op(xss_pkg::OP_START);
      put_rx(xss_pkg::CH_NAK);
      put_file(8'h80);
      put_op(xss_pkg::OP_EOF);
      send_slots(xss_pkg::FRAME_LEN);
      put_op(xss_pkg::OP_TXSLOT);
      put_rx(xss_pkg::CH_NAK);
      send_slots(xss_pkg::FRAME_LEN);
      put_rx(xss_pkg::CH_ACK);
      put_op(xss_pkg::OP_TXSLOT);
      put_rx(xss_pkg::CH_ACK);
   endtask

   // ------------------------------------------------------------------
   // Random transfers
   // ------------------------------------------------------------------

   // Play the receiver and the file source for one whole transfer, steered
   // by the predicted phase; a little noise of arbitrary requests mixed in.
   task automatic run_transfer(input int file_len);
      int         left;
      int         pick;
      logic [2:0] op;
      left = file_len;
      put_op(xss_pkg::OP_START);
      while (xfer_phase != xss_pkg::PH_DONE) begin
         if ($urandom_range(0, 99) < 2) begin
            op = 3'($urandom_range(0, 7));
            // keep aborts rare so most transfers run to the end
            if (op == xss_pkg::OP_ABORT && $urandom_range(0, 3) != 0) op = OP_UNUSED;
            send_request(op, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
         end else begin
            pick = $urandom_range(0, 99);
            case (xfer_phase)
               xss_pkg::PH_SYNC: begin
                  if (pick < 75) put_rx(xss_pkg::CH_NAK);
                  else if (pick < 88) put_op(xss_pkg::OP_TIMEOUT);
                  else put_rx(8'($urandom_range(0, 255)));
               end
               xss_pkg::PH_LOAD: begin
                  if (left > 0) begin
                     put_file(8'($urandom_range(0, 255)));
                     left--;
                  end else begin
                     put_op(xss_pkg::OP_EOF);
                  end
               end
               xss_pkg::PH_WAIT: begin
                  if (pick < 78) put_rx(xss_pkg::CH_ACK);
                  else if (pick < 88) put_rx(xss_pkg::CH_NAK);
                  else if (pick < 95) put_op(xss_pkg::OP_TIMEOUT);
                  else put_rx(8'($urandom_range(0, 255)));
               end
               xss_pkg::PH_EOTWAIT: begin
                  if (pick < 70) put_rx(xss_pkg::CH_ACK);
                  else if (pick < 85) put_rx(xss_pkg::CH_NAK);
                  else if (pick < 93) put_op(xss_pkg::OP_TIMEOUT);
                  else put_rx(8'($urandom_range(0, 255)));
               end
               default: begin
                  put_op(xss_pkg::OP_TXSLOT);
               end
            endcase
         end
      end
   endtask

   // new settings before each transfer; files mostly short, some around
   // one sector and some exactly one
   task automatic test_random_transfers(input int send_pct, input int rsp_pct,
                                        input int quota);
      int first;
      int pick;
      int len;
      send_idle_pct = send_pct;
      rsp_idle_pct  = rsp_pct;
      first = request_count;
      while (request_count - first < quota) begin
         settle();
         write_reg(xss_pkg::REG_RETRY_LIMIT, pick_limit());
         write_reg(xss_pkg::REG_SYNC_LIMIT, pick_limit());
         case ($urandom_range(0, 3))
            0:       write_reg(xss_pkg::REG_PAD_BYTE, 8'h00);
            1:       write_reg(xss_pkg::REG_PAD_BYTE, 8'hff);
            default: write_reg(xss_pkg::REG_PAD_BYTE, 8'($urandom_range(0, 255)));
         endcase
         pick = $urandom_range(0, 99);
         if (pick < 80) len = $urandom_range(0, 12);
         else if (pick < 90) len = $urandom_range(100, 140);
         else len = xss_pkg::SECTOR_BYTES;
         run_transfer(len);
      end
   endtask

   // ------------------------------------------------------------------
   // Sequence: reset, directed tests, random under three idle patterns
   // ------------------------------------------------------------------
   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_ignored_requests();
      test_sync_limits();
      test_empty_file();
      test_short_sector();
      test_random_transfers(25, 69, 40);
      test_random_transfers(69, 25, 40);
      test_random_transfers(0, 0, 40);
      settle();
      repeat (10) @(posedge clock);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// ===== xmodem_sector_sender.f =====
rtl/xss_pkg.sv
rtl/xmodem_sector_sender.sv
bench/tb_xmodem_sector_sender.sv
